// ===== rtl/mm64_pkg.sv =====
package mm64_pkg;

	localparam logic [63:0] MURMUR_M = 64'hc6a4a7935bd1e995;
	localparam logic [31:0] MUL_LO   = MURMUR_M[31:0];
	localparam logic [31:0] MUL_HI   = MURMUR_M[63:32];
	localparam int unsigned SHIFT_R  = 47;
	localparam logic [2:0]  TAIL_MASK = 3'h7;

	// Work that the back end does for one word.
	typedef enum logic [1:0] {
		OP_FULL,
		OP_TAIL,
		OP_FIN
	} op_t;

	typedef struct packed {
		logic [63:0] word;
		logic [31:0] len;
		op_t         op;
		logic        first;
		logic        last;
	} entry_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_SEED,
		C_KM1,
		C_KM2,
		C_HM,
		C_FM,
		C_OUT
	} core_state_t;

endpackage

// ===== rtl/mm64_in_if.sv =====
interface mm64_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic [31:0] message_length;
	logic        last;

	modport source (output valid, data_word, valid_bytes, message_length, last, input ready);
	modport sink (input valid, data_word, valid_bytes, message_length, last, output ready);
endinterface

// ===== rtl/mm64_out_if.sv =====
interface mm64_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

// ===== rtl/mm64_front.sv =====
module mm64_front
	import mm64_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	mm64_in_if.sink       msg,
	output logic          push_valid,
	input  logic          push_ready,
	output entry_t        push_data
);

	logic       open_q;
	logic       tail;
	logic [3:0] vb;

	assign vb   = msg.valid_bytes;
	assign tail = msg.last && !vb[3] && ((vb[2:0] & TAIL_MASK) != 3'd0);

	always_comb begin
		push_data.len   = msg.message_length;
		push_data.first = !open_q;
		push_data.last  = msg.last;
		if (!msg.last || vb[3]) begin
			push_data.op = OP_FULL;
		end else if (tail) begin
			push_data.op = OP_TAIL;
		end else begin
			push_data.op = OP_FIN;
		end
		// On the tail path only the low valid bytes are kept.
		for (int i = 0; i < 8; i++) begin
			if (!tail || (3'(i) < vb[2:0])) begin
				push_data.word[8*i +: 8] = msg.data_word[8*i +: 8];
			end else begin
				push_data.word[8*i +: 8] = 8'h00;
			end
		end
	end

	assign push_valid = msg.valid;
	assign msg.ready  = push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (msg.valid && push_ready) begin
			open_q <= !msg.last;
		end
	end

endmodule

// ===== rtl/mm64_fifo.sv =====
module mm64_fifo
	import mm64_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  entry_t push_data,
	output logic   pop_valid,
	input  logic   pop_ready,
	output entry_t pop_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/mm64_mul.sv =====
module mm64_mul
	import mm64_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] a,
	output logic        done,
	output logic [63:0] p
);

	// Low 64 bits of a * M from three 32x32 partial products, one per cycle while go is high.
	logic [1:0]  step_q;
	logic [63:0] acc_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	always_comb begin
		unique case (step_q)
			2'd0: begin
				op_a = a[31:0];
				op_b = MUL_LO;
			end
			2'd1: begin
				op_a = a[63:32];
				op_b = MUL_LO;
			end
			2'd2: begin
				op_a = a[31:0];
				op_b = MUL_HI;
			end
			2'd3: begin
				op_a = a[31:0];
				op_b = MUL_HI;
			end
		endcase
	end

	assign prod = {32'd0, op_a} * {32'd0, op_b};
	assign done = go && (step_q == 2'd3);
	assign p    = acc_q;

	always_ff @(posedge clk) begin
		if (go) begin
			if (step_q == 2'd0) begin
				acc_q <= prod;
			end else if (step_q != 2'd3) begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
		end else if (go) begin
			step_q <= step_q + 2'd1;
		end
	end

endmodule

// ===== rtl/mm64_core.sv =====
module mm64_core
	import mm64_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	output logic     pop_ready,
	input  entry_t   pop_data,
	mm64_out_if.source hash
);

	core_state_t state_q;
	core_state_t state_d;
	logic [63:0] h_q;
	logic [63:0] k_q;
	logic [31:0] len_q;
	op_t         op_q;
	logic        last_q;
	logic        out_valid_q;
	logic [63:0] out_hash_q;
	logic        mul_go;
	logic [63:0] mul_a;
	logic        mul_done;
	logic [63:0] mul_p;
	logic        do_pop;
	logic        out_free;
	logic        out_load;

	mm64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.done   (mul_done),
		.p      (mul_p)
	);

	function automatic core_state_t dispatch(input op_t op);
		core_state_t s;
		unique case (op)
			OP_FULL: s = C_KM1;
			OP_TAIL: s = C_HM;
			OP_FIN:  s = C_FM;
			default: s = C_FM;
		endcase
		return s;
	endfunction

	assign pop_ready = (state_q == C_IDLE);
	assign do_pop    = pop_valid && pop_ready;
	assign out_free  = !out_valid_q || hash.ready;
	assign out_load  = (state_q == C_OUT) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: begin
				if (pop_valid) begin
					state_d = pop_data.first ? C_SEED : dispatch(pop_data.op);
				end
			end
			C_SEED: if (mul_done) state_d = dispatch(op_q);
			C_KM1:  if (mul_done) state_d = C_KM2;
			C_KM2:  if (mul_done) state_d = C_HM;
			C_HM:   if (mul_done) state_d = last_q ? C_FM : C_IDLE;
			C_FM:   if (mul_done) state_d = C_OUT;
			C_OUT:  if (out_free) state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	always_comb begin
		mul_go = 1'b0;
		mul_a  = h_q ^ k_q;
		unique case (state_q)
			C_SEED: begin
				mul_go = 1'b1;
				mul_a  = {32'd0, len_q};
			end
			C_KM1, C_KM2: begin
				mul_go = 1'b1;
				mul_a  = k_q;
			end
			C_HM: begin
				mul_go = 1'b1;
				mul_a  = h_q ^ k_q;
			end
			C_FM: begin
				mul_go = 1'b1;
				mul_a  = h_q ^ (h_q >> SHIFT_R);
			end
			C_IDLE, C_OUT: begin
				mul_go = 1'b0;
			end
			default: mul_go = 1'b0;
		endcase
	end

	// Datapath. On the tail path k_q holds the masked word, so the hash
	// multiply always works on h ^ k.
	always_ff @(posedge clk) begin
		if (do_pop) begin
			k_q    <= pop_data.word;
			len_q  <= pop_data.len;
			op_q   <= pop_data.op;
			last_q <= pop_data.last;
		end
		if (mul_done) begin
			unique case (state_q)
				C_SEED:  h_q <= mul_p;
				C_KM1:   k_q <= mul_p ^ (mul_p >> SHIFT_R);
				C_KM2:   k_q <= mul_p;
				C_HM:    h_q <= mul_p;
				C_FM:    h_q <= mul_p ^ (mul_p >> SHIFT_R);
				default: h_q <= h_q;
			endcase
		end
		if (out_load) begin
			out_hash_q <= h_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (hash.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign hash.valid      = out_valid_q;
	assign hash.hash_value = out_hash_q;

endmodule

// ===== rtl/murmur2_64a_hash.sv =====
// MurmurHash64A with seed 0 over a message streamed as 64-bit words.
// The msg channel takes one little-endian word per transaction; the first
// word of a message also carries the total byte length, and last marks the
// final word, whose valid_bytes selects a full word, a tail of 1 to 7 bytes
// or a finalize-only step. The hash channel gives one 64-bit result per
// message, after its last word.
// A small queue sits between word intake and the hashing engine, so words
// are taken while the engine works and while a result waits on hash.
// Every 64-bit multiply by the constant runs on one 32x32 multiplier. An
// engine pass takes a word, seeds h with the length on a first word, then
// does the two key multiplies and the hash multiply for a full word, the
// hash multiply alone for a tail, and on a last word the finalization
// multiply and a load of the output register. The engine takes the next
// word from the queue only once its pass is over.
// Reset empties the queue, drops any open message and any pending result;
// the next word then starts a new message. A stalled hash receiver holds
// the result; once the engine has a second result ready, it waits, the
// queue fills and msg.ready goes low.
module murmur2_64a_hash
	import mm64_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	mm64_in_if.sink    msg,
	mm64_out_if.source hash
);

	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_data;

	mm64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mm64_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mm64_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.hash      (hash)
	);

	a_fin_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && (push_data.op == OP_FIN)) |-> push_data.last)
		else $error("finalize-only entry without last");

	a_mid_is_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_data.last) |-> (push_data.op == OP_FULL))
		else $error("non-last entry not classified as a full word");

	a_open_after_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready && !msg.last) |=> !push_data.first)
		else $error("word after a non-last word marked as message start");

	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && !pop_ready) |=> (pop_valid && $stable(pop_data)))
		else $error("queue head changed while the engine was busy");

endmodule
